[design/tkl_pkg.sv]
package tkl_pkg;

   localparam int KEY_CHAR_W = 8;
   localparam int DATA_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int MAP_DEPTH  = 128;
   localparam int MAP_AW     = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LINE_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALPHA_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NON_ASCII  = 2'd3;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic map_step;
      logic node_step;
   } tkl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic stall;
   } tkl_stat_type;

endpackage

[design/tkl_req_if.sv]
interface tkl_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [tkl_pkg::KEY_CHAR_W-1:0]  key_char;
   logic                            first_char;
   logic                            last_char;
   logic [tkl_pkg::DATA_W-1:0]      data_value;

   modport source (output valid, command, key_char, first_char, last_char, data_value,
                   input ready);
   modport sink (input valid, command, key_char, first_char, last_char, data_value,
                 output ready);
endinterface

[design/tkl_rsp_if.sv]
interface tkl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [tkl_pkg::DATA_W-1:0]     found_value;
   logic [tkl_pkg::STATUS_W-1:0]   status;

   modport source (output valid, found, found_value, status, input ready);
   modport sink (input valid, found, found_value, status, output ready);
endinterface

[design/trie_keyword_lookup_top.sv]
// Channel   Direction  Handshake          Contents
// req_if    in         valid/ready        command, key_char, first_char, last_char, data_value
// rsp_if    out        valid/ready        found, found_value, status
// csr       in         csr_wr_en          csr_wr_data sets case sensitivity
//
// A request passes through a character map read, then a dependent read and write of the
// node table, which is a single-port memory with registered read data.
// A response is produced only for a key's last character, and is held in an output register.
// After reset a clearing pass writes every node table entry, LINE_COUNT times the
// alphabet size rounded up to a power of two (65536 entries by default), with req_if.ready low.
// A last character waits in the node stage while the output register is still full.
module trie_keyword_lookup_top #(
   parameter int LINE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 64,
   parameter int VALUE_WIDTH   = 16
) (
   input  logic     clock,
   input  logic     reset,
   tkl_req_if.sink  req_if,
   tkl_rsp_if.source rsp_if,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);
   import tkl_pkg::*;

   tkl_cmd_type  cmd;
   tkl_stat_type stat;

   tkl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tkl_dp #(
      .LINE_COUNT    (LINE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .in_command      (req_if.command),
      .in_key_char     (req_if.key_char),
      .in_first_char   (req_if.first_char),
      .in_last_char    (req_if.last_char),
      .in_data_value   (req_if.data_value),
      .out_valid       (rsp_if.valid),
      .out_ready       (rsp_if.ready),
      .out_found       (rsp_if.found),
      .out_found_value (rsp_if.found_value),
      .out_status      (rsp_if.status)
   );

endmodule

[design/tkl_ctrl.sv]
module tkl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tkl_pkg::tkl_stat_type stat,
   output tkl_pkg::tkl_cmd_type  cmd
);
   import tkl_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_MAP   = 2'd2;
   localparam logic [1:0] S_NODE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_MAP;
            end
         end
         S_MAP: begin
            cmd.map_step = 1'b1;
            state_in     = S_NODE;
         end
         S_NODE: begin
            if (!stat.stall) begin
               cmd.node_step = 1'b1;
               req_ready     = 1'b1;
               if (req_valid) begin
                  cmd.load_item = 1'b1;
                  state_in      = S_MAP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_to_map: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == S_MAP)
      else $error("An accepted request did not move to the map stage.");

   a_map_to_node: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAP |=> state_ff == S_NODE)
      else $error("The map stage was not followed by the node stage.");

endmodule

[design/tkl_dp.sv]
module tkl_dp #(
   parameter int LINE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 64,
   parameter int VALUE_WIDTH   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tkl_pkg::tkl_cmd_type            cmd,
   output tkl_pkg::tkl_stat_type           stat,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  logic                            in_command,
   input  logic [tkl_pkg::KEY_CHAR_W-1:0]  in_key_char,
   input  logic                            in_first_char,
   input  logic                            in_last_char,
   input  logic [tkl_pkg::DATA_W-1:0]      in_data_value,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            out_found,
   output logic [tkl_pkg::DATA_W-1:0]      out_found_value,
   output logic [tkl_pkg::STATUS_W-1:0]    out_status
);
   import tkl_pkg::*;

   localparam int LINE_W     = $clog2(LINE_COUNT);
   localparam int USED_W     = $clog2(LINE_COUNT + 1);
   localparam int IDX_W      = $clog2(ALPHABET_SIZE);
   localparam int CNT_W      = $clog2(ALPHABET_SIZE + 1);
   localparam int ADDR_W     = LINE_W + IDX_W;
   localparam int NODE_DEPTH = LINE_COUNT * (2 ** IDX_W);
   localparam int ENTRY_W    = 1 + VALUE_WIDTH + LINE_W;

   localparam logic [KEY_CHAR_W-1:0] LOWER_A    = 8'h61;
   localparam logic [KEY_CHAR_W-1:0] LOWER_Z    = 8'h7a;
   localparam logic [KEY_CHAR_W-1:0] CASE_DELTA = 8'h20;

   logic                     case_sensitive_ff;
   logic [KEY_CHAR_W-1:0]    fold_char;
   logic [31:0]              data_ext;
   logic [31:0]              fval_ext;

   logic                     cmd_ff;
   logic [KEY_CHAR_W-1:0]    char_ff;
   logic                     first_ff;
   logic                     last_ff;
   logic [VALUE_WIDTH-1:0]   data_ff;

   logic [IDX_W-1:0]         map_mem [MAP_DEPTH];
   logic [MAP_DEPTH-1:0]     map_valid_ff;
   logic [IDX_W-1:0]         map_rd_ff;
   logic                     map_hit_ff;

   logic [CNT_W-1:0]         chars_ff;
   logic [CNT_W-1:0]         chars_in;
   logic [USED_W-1:0]        lines_used_ff;
   logic [USED_W-1:0]        lines_used_in;
   logic [LINE_W-1:0]        cur_line_ff;
   logic                     key_failed_ff;
   logic [STATUS_W-1:0]      err_ff;

   logic                     failed_map;
   logic [STATUS_W-1:0]      err_map;
   logic [LINE_W-1:0]        line_map;
   logic [IDX_W-1:0]         idx_map;
   logic                     map_wr;
   logic [ADDR_W-1:0]        node_addr;

   logic [ENTRY_W-1:0]       node_mem [NODE_DEPTH];
   logic [ENTRY_W-1:0]       node_rd_ff;
   logic [ADDR_W-1:0]        slot_ff;
   logic [ADDR_W-1:0]        clr_addr_ff;

   logic                     rd_end;
   logic [VALUE_WIDTH-1:0]   rd_val;
   logic [LINE_W-1:0]        rd_child;
   logic                     node_wr;
   logic [ENTRY_W-1:0]       node_wdata;
   logic                     failed_node;
   logic [STATUS_W-1:0]      err_node;
   logic [LINE_W-1:0]        line_node;
   logic                     found_node;
   logic [VALUE_WIDTH-1:0]   fval_node;

   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   // Unless case sensitivity is set, lower case letters are folded to upper case before the character map is read.
   always_comb begin
      fold_char = in_key_char;
      if (!case_sensitive_ff && in_key_char >= LOWER_A && in_key_char <= LOWER_Z) begin
         fold_char = in_key_char - CASE_DELTA;
      end
   end

   assign data_ext = 32'(in_data_value);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff     <= in_command;
         char_ff    <= fold_char;
         first_ff   <= in_first_char;
         last_ff    <= in_last_char;
         data_ff    <= data_ext[VALUE_WIDTH-1:0];
         map_rd_ff  <= map_mem[fold_char[MAP_AW-1:0]];
         map_hit_ff <= map_valid_ff[fold_char[MAP_AW-1:0]];
      end
      if (map_wr) begin
         map_mem[char_ff[MAP_AW-1:0]] <= chars_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      failed_map = first_ff ? 1'b0 : key_failed_ff;
      err_map    = first_ff ? STATUS_OK : err_ff;
      line_map   = first_ff ? '0 : cur_line_ff;
      idx_map    = map_rd_ff;
      chars_in   = chars_ff;
      map_wr     = 1'b0;
      if (!failed_map) begin
         if (char_ff[KEY_CHAR_W-1]) begin
            failed_map = 1'b1;
            err_map    = STATUS_NON_ASCII;
         end else if (!map_hit_ff) begin
            if (cmd_ff == CMD_SEARCH) begin
               failed_map = 1'b1;
            end else if (chars_ff == CNT_W'(ALPHABET_SIZE)) begin
               failed_map = 1'b1;
               err_map    = STATUS_ALPHA_FULL;
            end else begin
               map_wr   = cmd.map_step;
               idx_map  = chars_ff[IDX_W-1:0];
               chars_in = chars_ff + 1'b1;
            end
         end
      end
   end

   assign node_addr = {line_map, idx_map};

   assign rd_end   = node_rd_ff[ENTRY_W-1];
   assign rd_val   = node_rd_ff[LINE_W +: VALUE_WIDTH];
   assign rd_child = node_rd_ff[LINE_W-1:0];

   always_comb begin
      node_wr       = 1'b0;
      node_wdata    = node_rd_ff;
      failed_node   = key_failed_ff;
      err_node      = err_ff;
      line_node     = cur_line_ff;
      lines_used_in = lines_used_ff;
      found_node    = 1'b0;
      fval_node     = '0;
      if (!key_failed_ff) begin
         if (last_ff) begin
            if (cmd_ff == CMD_SEARCH) begin
               if (rd_end) begin
                  found_node = 1'b1;
                  fval_node  = rd_val;
               end
            end else begin
               node_wr    = 1'b1;
               node_wdata = {1'b1, data_ff, rd_child};
            end
         end else if (rd_child != '0) begin
            line_node = rd_child;
         end else if (cmd_ff == CMD_SEARCH) begin
            failed_node = 1'b1;
         end else if (lines_used_ff == USED_W'(LINE_COUNT)) begin
            failed_node = 1'b1;
            err_node    = STATUS_LINE_FULL;
         end else begin
            node_wr       = 1'b1;
            node_wdata    = {rd_end, rd_val, lines_used_ff[LINE_W-1:0]};
            line_node     = lines_used_ff[LINE_W-1:0];
            lines_used_in = lines_used_ff + 1'b1;
         end
      end
   end

   assign fval_ext = 32'(fval_node);

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         node_mem[clr_addr_ff] <= '0;
      end else if (cmd.node_step && node_wr) begin
         node_mem[slot_ff] <= node_wdata;
      end
      if (cmd.map_step) begin
         node_rd_ff <= node_mem[node_addr];
         slot_ff    <= node_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign stat = '{clear_done: (clr_addr_ff == ADDR_W'(NODE_DEPTH - 1)),
                   stall:      (last_ff && rsp_valid_ff && !out_ready)};

   always_ff @(posedge clock) begin
      if (reset) begin
         case_sensitive_ff <= 1'b0;
         map_valid_ff      <= '0;
         chars_ff          <= '0;
         lines_used_ff     <= USED_W'(1);
         cur_line_ff       <= '0;
         key_failed_ff     <= 1'b0;
         err_ff            <= STATUS_OK;
      end else begin
         if (csr_wr_en) begin
            case_sensitive_ff <= csr_wr_data;
         end
         if (map_wr) begin
            map_valid_ff[char_ff[MAP_AW-1:0]] <= 1'b1;
         end
         if (cmd.map_step) begin
            chars_ff      <= chars_in;
            cur_line_ff   <= line_map;
            key_failed_ff <= failed_map;
            err_ff        <= err_map;
         end
         if (cmd.node_step) begin
            lines_used_ff <= lines_used_in;
            if (last_ff) begin
               cur_line_ff   <= '0;
               key_failed_ff <= 1'b0;
               err_ff        <= STATUS_OK;
            end else begin
               cur_line_ff   <= line_node;
               key_failed_ff <= failed_node;
               err_ff        <= err_node;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.node_step && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.node_step && last_ff) begin
         rsp_found_ff  <= found_node;
         rsp_value_ff  <= fval_ext[DATA_W-1:0];
         rsp_status_ff <= err_ff;
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign out_found       = rsp_found_ff;
   assign out_found_value = rsp_value_ff;
   assign out_status      = rsp_status_ff;

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.node_step && last_ff |=> rsp_valid_ff)
      else $error("A request ending a key did not load a result.");

   a_lines_step: assert property (@(posedge clock) disable iff (reset)
      cmd.node_step |=> lines_used_ff == $past(lines_used_ff)
                        || lines_used_ff == $past(lines_used_ff) + 1'b1)
      else $error("The line count moved by more than one.");

   a_chars_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.map_step |=> $stable(chars_ff))
      else $error("The alphabet count changed outside the map stage.");

endmodule
